/* hdl/doi_pkg.sv */
package doi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COEF_FRAC = 16;

   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_HOLD    = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_STIFF = 2'd1;
   localparam logic [1:0] CSR_DAMP  = 2'd2;

   localparam logic [23:0] STIFF_RESET = 24'd655360;
   localparam logic [23:0] DAMP_RESET  = 24'd32768;

   localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAT_MIN = -32'sh7fffffff - 32'sd1;

   // multiplier handshake between sequencer and serial multiplier
   typedef struct packed {
      logic               start;
      logic signed [31:0] a;
      logic [23:0]        b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] q;
   } mul_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
      logic signed [31:0] r;
      if (x > 34'(SAT_MAX)) r = SAT_MAX;
      else if (x < 34'(SAT_MIN)) r = SAT_MIN;
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      return sat32(34'(a) + 34'(b));
   endfunction

   function automatic logic signed [31:0] halve(input logic signed [31:0] a);
      return a >>> 1;
   endfunction

endpackage

/* hdl/damped_oscillator_integrator_core.sv */
// damped spring oscillator integrator, q16.16 angle and velocity. each req
// transfer gives one rsp transfer carrying the state after it. hold, release,
// inactive ticks and the unused request code go straight to the response; an
// euler tick uses four products and a runge-kutta tick sixteen, each taken by
// one shared bit-serial multiplier, and a runge-kutta tick adds two serial
// divides by six. the block takes one item at a time; csr writes are taken
// whenever no item is in work and no rsp transfer is waiting.
module damped_oscillator_integrator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [15:0]        req_time_step,
   input  logic signed [31:0] req_hold_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_angle_out,
   output logic signed [31:0] rsp_velocity_out,
   output logic               rsp_moving,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_data
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_WAIT, ST_DIV, ST_FIN, ST_OUT
   } state_type;

   // product slots: per stage kx, k*x, c*v, kv
   localparam logic [1:0] OP_KX = 2'd0, OP_KXP = 2'd1, OP_CVP = 2'd2, OP_KV = 2'd3;

   state_type          state_ff, state_in;
   logic               mode_ff;
   logic [23:0]        stiff_ff, damp_ff;
   logic signed [31:0] x_ff, v_ff;
   logic               active_ff;
   logic [15:0]        dt_ff;
   logic [1:0]         stg_ff;
   logic [1:0]         op_ff;
   logic signed [31:0] xs_ff, vs_ff;    // stage inputs
   logic signed [31:0] kxp_ff, kx_ff, acc_ff;
   logic signed [34:0] sx_ff, sv_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] angle_o_ff, vel_o_ff;
   logic               moving_o_ff;
   // divide by six, restoring, one quotient bit per cycle
   logic [35:0]        dnum_ff;
   logic [35:0]        drem_ff;
   logic [35:0]        dq_ff;
   logic               dneg_ff;
   logic [5:0]         dcnt_ff;
   logic               dsel_ff;  // 0 angle, 1 velocity

   doi_pkg::mul_req_type mreq;
   doi_pkg::mul_rsp_type mrsp;

   doi_mul u_mul (.clock(clock), .reset(reset), .mreq(mreq), .mrsp(mrsp));

   logic signed [31:0] one_q;
   logic signed [31:0] hold_cl;
   logic signed [31:0] accel;
   logic signed [31:0] next_xs, next_vs, kq;
   logic [35:0]        rem_sh;
   logic signed [35:0] qdiv;

   assign one_q = 32'sd1 <<< doi_pkg::FRAC_BITS;
   always_comb begin
      if (req_hold_angle > one_q) hold_cl = one_q;
      else if (req_hold_angle < -one_q) hold_cl = -one_q;
      else hold_cl = req_hold_angle;
      accel = doi_pkg::sat32(-34'(kxp_ff) - 34'(mrsp.q));
      kq    = mrsp.q;
      // next runge-kutta stage inputs from kx_ff and kv (kq)
      if (stg_ff == 2'd2) begin
         next_xs = doi_pkg::add_sat(x_ff, kx_ff);
         next_vs = doi_pkg::add_sat(v_ff, kq);
      end else begin
         next_xs = doi_pkg::add_sat(x_ff, doi_pkg::halve(kx_ff));
         next_vs = doi_pkg::add_sat(v_ff, doi_pkg::halve(kq));
      end
      rem_sh = {drem_ff[34:0], dnum_ff[35]};
      qdiv   = dneg_ff ? -$signed(dq_ff) : $signed(dq_ff);
   end

   // multiplier operands by slot
   always_comb begin
      mreq.start = (state_ff == ST_MUL);
      mreq.a     = vs_ff;
      mreq.b     = {8'd0, dt_ff};
      unique case (op_ff)
         OP_KX:  begin mreq.a = vs_ff;  mreq.b = {8'd0, dt_ff}; end
         OP_KXP: begin mreq.a = xs_ff;  mreq.b = stiff_ff; end
         OP_CVP: begin mreq.a = vs_ff;  mreq.b = damp_ff; end
         OP_KV:  begin mreq.a = acc_ff; mreq.b = {8'd0, dt_ff}; end
         default: ;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign csr_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid && !req_stall && req_type == doi_pkg::REQ_TICK && active_ff)
                     state_in = ST_MUL;
                  else if (req_valid && !req_stall) state_in = ST_OUT;
         ST_MUL:  state_in = ST_WAIT;
         ST_WAIT: if (mrsp.done) begin
                     if (op_ff == OP_KV && (mode_ff || stg_ff == 2'd3))
                        state_in = mode_ff ? ST_OUT : ST_DIV;
                     else state_in = ST_MUL;
                  end
         ST_DIV:  if (dcnt_ff == 6'd36) state_in = dsel_ff ? ST_FIN : ST_DIV;
         ST_FIN:  state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         stiff_ff     <= doi_pkg::STIFF_RESET;
         damp_ff      <= doi_pkg::DAMP_RESET;
         x_ff         <= '0;
         v_ff         <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= OP_KX;
         stg_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               doi_pkg::CSR_MODE:  mode_ff  <= csr_data[0];
               doi_pkg::CSR_STIFF: stiff_ff <= csr_data;
               doi_pkg::CSR_DAMP:  damp_ff  <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: if (req_valid && !req_stall) begin
               dt_ff  <= req_time_step;
               xs_ff  <= x_ff;
               vs_ff  <= v_ff;
               sx_ff  <= '0;
               sv_ff  <= '0;
               stg_ff <= '0;
               op_ff  <= OP_KX;
               if (req_type == doi_pkg::REQ_HOLD) begin
                  x_ff      <= hold_cl;
                  active_ff <= 1'b0;
               end else if (req_type == doi_pkg::REQ_RELEASE) begin
                  v_ff      <= '0;
                  active_ff <= 1'b1;
               end
            end
            ST_WAIT: if (mrsp.done) begin
               unique case (op_ff)
                  OP_KX: begin
                     kx_ff <= kq;
                     if (mode_ff) begin
                        // euler: position first, then force on new position
                        xs_ff <= doi_pkg::add_sat(x_ff, kq);
                        x_ff  <= doi_pkg::add_sat(x_ff, kq);
                     end
                     op_ff <= OP_KXP;
                  end
                  OP_KXP: begin kxp_ff <= kq; op_ff <= OP_CVP; end
                  OP_CVP: begin acc_ff <= accel; op_ff <= OP_KV; end
                  OP_KV: begin
                     op_ff <= OP_KX;
                     if (mode_ff) v_ff <= doi_pkg::add_sat(v_ff, kq);
                     else begin
                        if (stg_ff == 2'd1 || stg_ff == 2'd2) begin
                           sx_ff <= sx_ff + 35'(kx_ff) + 35'(kx_ff);
                           sv_ff <= sv_ff + 35'(kq) + 35'(kq);
                        end else begin
                           sx_ff <= sx_ff + 35'(kx_ff);
                           sv_ff <= sv_ff + 35'(kq);
                        end
                        xs_ff  <= next_xs;
                        vs_ff  <= next_vs;
                        stg_ff <= stg_ff + 2'd1;
                        if (stg_ff == 2'd3) begin
                           // load angle sum into divider: sign of s+3, magnitude plus five if negative
                           dsel_ff <= 1'b0;
                           dcnt_ff <= '0;
                           drem_ff <= '0;
                           dq_ff   <= '0;
                           begin
                              logic signed [35:0] t;
                              t = 36'(sx_ff) + 36'(kx_ff) + 36'sd3;
                              dneg_ff <= t[35];
                              dnum_ff <= t[35] ? 36'(-t) + 36'd5 : t;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
            ST_DIV: begin
               if (dcnt_ff != 6'd36) begin
                  dnum_ff <= dnum_ff << 1;
                  if (rem_sh >= 36'd6) begin
                     drem_ff <= rem_sh - 36'd6;
                     dq_ff   <= {dq_ff[34:0], 1'b1};
                  end else begin
                     drem_ff <= rem_sh;
                     dq_ff   <= {dq_ff[34:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff + 6'd1;
               end else if (!dsel_ff) begin
                  // angle quotient ready, start velocity sum
                  x_ff    <= doi_pkg::sat32(34'(x_ff) + 34'(qdiv));
                  dsel_ff <= 1'b1;
                  dcnt_ff <= '0;
                  drem_ff <= '0;
                  dq_ff   <= '0;
                  begin
                     logic signed [35:0] t;
                     t = 36'(sv_ff) + 36'sd3;
                     dneg_ff <= t[35];
                     dnum_ff <= t[35] ? 36'(-t) + 36'd5 : t;
                  end
               end else begin
                  v_ff <= doi_pkg::sat32(34'(v_ff) + 34'(qdiv));
               end
            end
            ST_OUT: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
      if (state_ff == ST_OUT) begin
         angle_o_ff  <= x_ff;
         vel_o_ff    <= v_ff;
         moving_o_ff <= active_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_angle_out    = angle_o_ff;
   assign rsp_velocity_out = vel_o_ff;
   assign rsp_moving       = moving_o_ff;
endmodule

/* hdl/doi_mul.sv */
// bit-serial signed x unsigned multiply, one multiplier bit per cycle,
// rounded and saturated q16 result
module doi_mul (
   input  logic                clock,
   input  logic                reset,
   input  doi_pkg::mul_req_type mreq,
   output doi_pkg::mul_rsp_type mrsp
);
   logic signed [56:0] acc_ff, acc_in;
   logic signed [56:0] mcand_ff, mcand_in;
   logic [23:0]        mplier_ff, mplier_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [31:0] q_ff, q_in;
   logic signed [56:0] rnd;
   logic signed [40:0] shr;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      q_in      = q_ff;
      rnd       = acc_ff + 57'sd32768;
      shr       = 41'(rnd >>> doi_pkg::COEF_FRAC);
      if (mreq.start) begin
         acc_in    = '0;
         mcand_in  = 57'(mreq.a);
         mplier_in = mreq.b;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 5'd1;
         if (cnt_ff == 5'd23) busy_in = 1'b0;
         if (cnt_ff == 5'd23) done_in = 1'b0;
      end else if (cnt_ff == 5'd24) begin
         if (shr > 41'(doi_pkg::SAT_MAX)) q_in = doi_pkg::SAT_MAX;
         else if (shr < 41'(doi_pkg::SAT_MIN)) q_in = doi_pkg::SAT_MIN;
         else q_in = shr[31:0];
         done_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      q_ff      <= q_in;
   end

   assign mrsp.done = done_ff;
   assign mrsp.q    = q_ff;
endmodule

/* test/damped_oscillator_integrator_core_tb.sv */
module damped_oscillator_integrator_core_tb;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_type;
   logic [15:0]        req_time_step;
   logic signed [31:0] req_hold_angle;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_angle_out;
   logic signed [31:0] rsp_velocity_out;
   logic               rsp_moving;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [23:0]        csr_data;

   damped_oscillator_integrator_core uut (.*);

   // unused request code and unused register index
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // 20 unit clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // oscillator state expected after each transfer
   typedef struct {
      logic signed [31:0] angle;
      logic signed [31:0] velocity;
      logic               moving;
   } osc_state_type;

   // predictor copy of state and registers
   logic               pred_euler;
   logic [23:0]        pred_stiff;
   logic [23:0]        pred_damp;
   logic signed [31:0] pred_angle;
   logic signed [31:0] pred_velocity;
   logic               pred_moving;

   osc_state_type expected_states[$];
   int         error_count;
   int         rsp_count;
   int         tick_count;
   int         hold_count;
   longint     cycle_count;
   bit         long_hold_off;
   int         hold_off_cycles;

   localparam longint CYCLE_LIMIT = 3_000_000;
   localparam int     HOLD_OFF_LEN = 600;

   function automatic logic signed [31:0] clip32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > 66'sd2147483647) r = 32'sh7fffffff;
      else if (x < -66'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

   // state value times q.16 coefficient, round half up, saturate
   function automatic logic signed [31:0] scale_q16(input logic signed [31:0] a,
                                                    input logic [23:0] b);
      logic signed [65:0] p;
      p = 66'(a) * $signed({42'd0, b});
      p = (p + 66'sd32768) >>> 16;
      return clip32(p);
   endfunction

   function automatic logic signed [31:0] sum_clip(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      return clip32(66'(a) + 66'(b));
   endfunction

   function automatic logic signed [31:0] spring_accel(input logic signed [31:0] x,
                                                       input logic signed [31:0] v);
      return clip32(-66'(scale_q16(x, pred_stiff)) - 66'(scale_q16(v, pred_damp)));
   endfunction

   // divide by six, nearest, ties toward +inf (floor of (s+3)/6)
   function automatic logic signed [65:0] sixth(input logic signed [65:0] s);
      logic signed [65:0] t;
      t = s + 66'sd3;
      if (t >= 0) return t / 6;
      return -(((-t) + 66'sd5) / 6);
   endfunction

   task automatic rk4_advance(input logic [23:0] dt);
      logic signed [31:0] x, v, kx0, kv0, kx1, kv1, kx2, kv2, kx3, kv3, v1, v2, v3;
      logic signed [65:0] sx, sv;
      x = pred_angle;
      v = pred_velocity;
      kx0 = scale_q16(v, dt);
      kv0 = scale_q16(spring_accel(x, v), dt);
      v1 = sum_clip(v, kv0 >>> 1);
      kx1 = scale_q16(v1, dt);
      kv1 = scale_q16(spring_accel(sum_clip(x, kx0 >>> 1), v1), dt);
      v2 = sum_clip(v, kv1 >>> 1);
      kx2 = scale_q16(v2, dt);
      kv2 = scale_q16(spring_accel(sum_clip(x, kx1 >>> 1), v2), dt);
      v3 = sum_clip(v, kv2);
      kx3 = scale_q16(v3, dt);
      kv3 = scale_q16(spring_accel(sum_clip(x, kx2), v3), dt);
      sx = 66'(kx0) + 2 * 66'(kx1) + 2 * 66'(kx2) + 66'(kx3);
      sv = 66'(kv0) + 2 * 66'(kv1) + 2 * 66'(kv2) + 66'(kv3);
      pred_angle = clip32(66'(x) + sixth(sx));
      pred_velocity = clip32(66'(v) + sixth(sv));
   endtask

   task automatic predict_oscillator(input logic [1:0] kind, input logic [15:0] dt,
                                     input logic signed [31:0] target);
      osc_state_type s;
      case (kind)
         doi_pkg::REQ_TICK: begin
            tick_count++;
            if (pred_moving) begin
               if (!pred_euler) rk4_advance({8'd0, dt});
               else begin
                  pred_angle = sum_clip(pred_angle, scale_q16(pred_velocity, {8'd0, dt}));
                  pred_velocity = sum_clip(pred_velocity,
                     scale_q16(spring_accel(pred_angle, pred_velocity), {8'd0, dt}));
               end
            end
         end
         doi_pkg::REQ_HOLD: begin
            hold_count++;
            if (target > 32'sh00010000) pred_angle = 32'sh00010000;
            else if (target < -32'sh00010000) pred_angle = -32'sh00010000;
            else pred_angle = target;
            pred_moving = 1'b0;
         end
         doi_pkg::REQ_RELEASE: begin
            pred_velocity = '0;
            pred_moving = 1'b1;
         end
         default: ;
      endcase
      s.angle = pred_angle;
      s.velocity = pred_velocity;
      s.moving = pred_moving;
      expected_states.push_back(s);
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // one transfer on the req channel
   task automatic send_item(input logic [1:0] kind, input logic [15:0] dt,
                            input logic signed [31:0] target);
      int gap;
      req_valid <= 1'b1;
      req_type <= kind;
      req_time_step <= dt;
      req_hold_angle <= target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_oscillator(kind, dt, target);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_states.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // csr transfer, only called with the block idle
   task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         doi_pkg::CSR_MODE:  pred_euler = value[0];
         doi_pkg::CSR_STIFF: pred_stiff = value;
         doi_pkg::CSR_DAMP:  pred_damp = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // rsp side: random stall plus a periodic stall stretch; a long hold-off stalls until HOLD_OFF_LEN is reached
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_off_cycles = 0;
      end else if (long_hold_off) begin
         rsp_stall <= 1'b1;
         hold_off_cycles++;
         if (hold_off_cycles >= HOLD_OFF_LEN) begin
            long_hold_off = 1'b0;
            hold_off_cycles = 0;
         end
      end else rsp_stall <= ($urandom_range(0, 9) < 3) || (cycle_count % 2000 > 1900);
   end

   // compare every rsp transfer against the oldest expectation
   always @(posedge clock) begin
      osc_state_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_states.size() == 0) begin
            $error("unexpected rsp transfer: angle %0d", rsp_angle_out);
            error_count++;
         end else begin
            e = expected_states.pop_front();
            rsp_count++;
            if (rsp_angle_out !== e.angle) begin
               $error("angle_out expected %0d got %0d", e.angle, rsp_angle_out);
               error_count++;
            end
            if (rsp_velocity_out !== e.velocity) begin
               $error("velocity_out expected %0d got %0d", e.velocity, rsp_velocity_out);
               error_count++;
            end
            if (rsp_moving !== e.moving) begin
               $error("moving expected %0d got %0d", e.moving, rsp_moving);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // directed rows: kind, dt, hold angle, and a typed-in expectation where obvious
   typedef struct {
      logic [1:0]         kind;
      logic [15:0]        dt;
      logic signed [31:0] target;
      bit                 known;
      logic signed [31:0] angle;
      logic signed [31:0] velocity;
      logic               moving;
   } stim_row_type;

   stim_row_type directed_rows[] = '{
      '{doi_pkg::REQ_TICK,    16'hffff, 32'sd0,        1, 32'sd0,      32'sd0, 1'b0},
      '{REQ_UNUSED,           16'h1234, 32'sd5,        1, 32'sd0,      32'sd0, 1'b0},
      '{doi_pkg::REQ_HOLD,    16'h0000, 32'sh7fffffff, 1, 32'sh10000,  32'sd0, 1'b0},
      '{doi_pkg::REQ_HOLD,    16'hffff, 32'sh80000000, 1, -32'sh10000, 32'sd0, 1'b0},
      '{doi_pkg::REQ_HOLD,    16'h0000, 32'sh00010001, 1, 32'sh10000,  32'sd0, 1'b0},
      '{doi_pkg::REQ_HOLD,    16'h0000, -32'sh00010001, 1, -32'sh10000, 32'sd0, 1'b0},
      '{doi_pkg::REQ_HOLD,    16'h0000, 32'sh00008000, 1, 32'sh8000,   32'sd0, 1'b0},
      '{doi_pkg::REQ_TICK,    16'h0444, 32'sd0,        1, 32'sh8000,   32'sd0, 1'b0},
      '{doi_pkg::REQ_RELEASE, 16'h0000, 32'sh55555555, 1, 32'sh8000,   32'sd0, 1'b1},
      '{doi_pkg::REQ_TICK,    16'h0000, 32'sd0,        0, 0, 0, 0},
      '{doi_pkg::REQ_TICK,    16'h0444, 32'sd0,        0, 0, 0, 0},
      '{doi_pkg::REQ_TICK,    16'hffff, 32'sd0,        0, 0, 0, 0},
      '{doi_pkg::REQ_TICK,    16'h8000, 32'shaaaaaaaa, 0, 0, 0, 0},
      '{REQ_UNUSED,           16'hffff, 32'sd0,        0, 0, 0, 0},
      '{doi_pkg::REQ_HOLD,    16'h0000, -32'sd1,       0, 0, 0, 0},
      '{doi_pkg::REQ_RELEASE, 16'h0000, 32'sd0,        1, -32'sd1,     32'sd0, 1'b1},
      '{doi_pkg::REQ_TICK,    16'h0001, 32'sd0,        0, 0, 0, 0},
      '{doi_pkg::REQ_TICK,    16'h7fff, 32'sd0,        0, 0, 0, 0}
   };

   initial begin
      logic [1:0]         kind;
      logic signed [31:0] target;
      int                 r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = '0;
      req_time_step = '0;
      req_hold_angle = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      long_hold_off = 1'b0;
      cycle_count = 0;
      error_count = 0;
      rsp_count = 0;
      tick_count = 0;
      hold_count = 0;
      pred_euler = 1'b0;
      pred_stiff = doi_pkg::STIFF_RESET;
      pred_damp = doi_pkg::DAMP_RESET;
      pred_angle = '0;
      pred_velocity = '0;
      pred_moving = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with reset registers
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].kind, directed_rows[i].dt, directed_rows[i].target);
         if (directed_rows[i].known) begin
            if (pred_angle !== directed_rows[i].angle
                || pred_velocity !== directed_rows[i].velocity
                || pred_moving !== directed_rows[i].moving) begin
               $error("directed row %0d: predictor disagrees with table", i);
               error_count++;
            end
         end
      end
      end_burst();
      wait_drained();

      // register settings, extremes included; the unused index must be ignored
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin write_reg(doi_pkg::CSR_MODE, 24'hfffffe);
                     write_reg(doi_pkg::CSR_STIFF, 24'hffffff);
                     write_reg(doi_pkg::CSR_DAMP, 24'hffffff); end
            1: begin write_reg(doi_pkg::CSR_MODE, 24'h000001);
                     write_reg(doi_pkg::CSR_STIFF, 24'h000000);
                     write_reg(doi_pkg::CSR_DAMP, 24'h000000); end
            2: begin write_reg(doi_pkg::CSR_MODE, 24'hffffff);
                     write_reg(doi_pkg::CSR_STIFF, 24'hffffff);
                     write_reg(doi_pkg::CSR_DAMP, 24'h000000); end
            3: begin write_reg(doi_pkg::CSR_MODE, 24'h000000);
                     write_reg(doi_pkg::CSR_STIFF, doi_pkg::STIFF_RESET);
                     write_reg(doi_pkg::CSR_DAMP, doi_pkg::DAMP_RESET);
                     write_reg(CSR_UNUSED, 24'h123456); end
            default: begin
               write_reg(doi_pkg::CSR_MODE, 24'($urandom));
               write_reg(doi_pkg::CSR_STIFF, ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                             : 24'($urandom_range(0, 2000000)));
               write_reg(doi_pkg::CSR_DAMP, 24'($urandom));
            end
         endcase

         // one phase lets the rsp side hold off long while items keep coming
         if (phase == 4) long_hold_off = 1'b1;
         for (int n = 0; n < 60; n++) begin
            r = $urandom_range(0, 99);
            // mostly ticks, with holds, releases and the odd unused code
            if (r < 70) kind = doi_pkg::REQ_TICK;
            else if (r < 82) kind = doi_pkg::REQ_HOLD;
            else if (r < 95) kind = doi_pkg::REQ_RELEASE;
            else kind = REQ_UNUSED;
            if ($urandom_range(0, 1) == 0) target = $signed($urandom_range(0, 131072)) - 65536;
            else target = $signed($urandom);
            send_item(kind, ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 4000)),
                      target);
            // sender pause until all results are in
            if (n == 30 && phase == 5) begin
               end_burst();
               while (expected_states.size() != 0) @(posedge clock);
            end
         end
         end_burst();
         wait_drained();
      end

      $display("covered %0d results: %0d ticks, %0d holds, both integrators, %s",
               rsp_count, tick_count, hold_count, "extreme coefficients and time steps");
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
